/* hdl/rgb_to_hsl_converter_unit_defines.svh */
// ---------------------------------------------------------------------------
// RGB to HSL converter assertion macros
// Shared concurrent assertion helpers for the converter RTL.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CONVERTER_UNIT_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_UNIT_DEFINES_SVH

// Assertion on an explicit clock, disabled while reset is asserted.
`define RHSL_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block's own clock and reset.
`define RHSL_ASSERT(label, prop, msg) \
    `RHSL_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

/* hdl/rhsl_pkg.sv */
// ---------------------------------------------------------------------------
// RGB to HSL converter package
// Types shared by the converter RTL.
// ---------------------------------------------------------------------------
package rhsl_pkg;

    // Which channel holds the maximum, and so which third of the hue circle.
    typedef enum logic [1:0] {
        BR_RED   = 2'd0,
        BR_GREEN = 2'd1,
        BR_BLUE  = 2'd2
    } t_hue_branch;

endpackage

/* hdl/rhsl_div.sv */
// ---------------------------------------------------------------------------
// RGB to HSL pipelined divider
// Restoring unsigned division, one quotient bit per register stage. The
// caller guarantees that the quotient fits in QUO_W bits, which means the
// numerator is DEN_W + QUO_W bits wide and its upper DEN_W bits are below
// the divisor.
// ---------------------------------------------------------------------------
module rhsl_div #(
    parameter int DEN_W = 8,
    parameter int QUO_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [DEN_W+QUO_W-1:0]   i_num,
    input  logic [DEN_W-1:0]         i_den,
    output logic [QUO_W-1:0]         o_quo
);

    // Stage 0 holds the loaded operands, stage k holds k quotient bits.
    logic [DEN_W-1:0] r_rem [0:QUO_W];
    logic [QUO_W-1:0] r_low [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];

    // Load the partial remainder with the upper numerator bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num[DEN_W+QUO_W-1:QUO_W];
            r_low[0] <= i_num[QUO_W-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
        end
    end

    // One trial subtraction per stage.
    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [DEN_W:0] w_trial;
        logic [DEN_W:0] w_diff;
        logic           w_fit;

        assign w_trial = {r_rem[k-1], r_low[k-1][QUO_W-1]};
        assign w_diff  = w_trial - {1'b0, r_den[k-1]};
        assign w_fit   = (w_trial >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_fit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_low[k] <= {r_low[k-1][QUO_W-2:0], 1'b0};
                r_quo[k] <= {r_quo[k-1][QUO_W-2:0], w_fit};
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_quo = r_quo[QUO_W];

endmodule

/* hdl/rgb_to_hsl_converter_unit.sv */
// Pipeline: stage 1, stage 2, the stages of the two dividers, the output register.
// Throughput: one pixel per cycle unless stalled; one quotient bit per divider stage.
// A stall at the output holds the whole pipeline in place, nothing is dropped.
// Reset (synchronous, active low) clears only the stage valid bits.
// ---------------------------------------------------------------------------
// RGB to HSL converter top level
// Finds max/min of the channels, forms the hue and saturation numerators and
// divisors and divides them in two pipelined dividers. Lightness divides by
// a constant and uses a reciprocal multiplication at the output stage.
// ---------------------------------------------------------------------------
`include "rgb_to_hsl_converter_unit_defines.svh"

module rgb_to_hsl_converter_unit #(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [CHANNEL_BITS-1:0]  i_red,
    input  logic [CHANNEL_BITS-1:0]  i_green,
    input  logic [CHANNEL_BITS-1:0]  i_blue,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [FRACTION_BITS-1:0] o_hue,
    output logic [FRACTION_BITS-1:0] o_saturation,
    output logic [FRACTION_BITS-1:0] o_lightness
);

    localparam int C   = CHANNEL_BITS;
    localparam int F   = FRACTION_BITS;
    localparam int LAT = F + 4;
    // Twice the largest channel code, the lightness divisor.
    localparam logic [C:0] LIG_DEN = {{C{1'b1}}, 1'b0};

    // Lightness is sum * (2^F - 1) / LIG_DEN. A rounded-up reciprocal scaled
    // by 2^LIG_SHIFT gives the exact floor for every sum of two codes, since
    // the sum times the divisor stays below 2^LIG_SHIFT.
    localparam int LIG_SHIFT = 2 * C + 2;
    localparam int LIG_MW    = F + C + 2;
    localparam int LIG_PW    = C + 1 + LIG_MW;
    localparam longint unsigned LIG_DIV   = (64'd1 << (C + 1)) - 64'd2;
    localparam longint unsigned LIG_RECIP =
        ((((64'd1 << F) - 64'd1) << LIG_SHIFT) + LIG_DIV - 64'd1) / LIG_DIV;
    localparam logic [LIG_MW-1:0] LIG_MUL = LIG_MW'(LIG_RECIP);

    logic w_adv;
    logic [LAT-1:0] r_vld;

    // The pipeline moves whenever the output register is free or drained.
    assign w_adv   = !r_vld[LAT-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Stage 1: maximum, minimum and the winning channel.
    logic [C-1:0] r_red, r_grn, r_blu, r_mx, r_mn;
    rhsl_pkg::t_hue_branch r_br;
    logic [C-1:0] n_mx, n_mn;
    rhsl_pkg::t_hue_branch n_br;

    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n_br = rhsl_pkg::BR_RED;
            n_mx = i_red;
        end else if (i_green >= i_blue) begin
            n_br = rhsl_pkg::BR_GREEN;
            n_mx = i_green;
        end else begin
            n_br = rhsl_pkg::BR_BLUE;
            n_mx = i_blue;
        end
        n_mn = i_red;
        if (i_green < n_mn) begin
            n_mn = i_green;
        end
        if (i_blue < n_mn) begin
            n_mn = i_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_red <= i_red;
            r_grn <= i_green;
            r_blu <= i_blue;
            r_mx  <= n_mx;
            r_mn  <= n_mn;
            r_br  <= n_br;
        end
    end

    // Stage 2: sum, spread, saturation and hue divisors, hue numerator and grey flag.
    logic [C:0]   r_sum, n_sum;
    logic [C-1:0] r_d, n_d;
    logic [C-1:0] r_den, n_den;
    logic [C+2:0] r_d6, n_d6;
    logic [C+2:0] r_num, n_num;
    logic         r_grey;
    logic [C+2:0] w_r, w_g, w_b, w_d;

    assign w_r = (C+3)'(r_red);
    assign w_g = (C+3)'(r_grn);
    assign w_b = (C+3)'(r_blu);
    assign w_d = (C+3)'(n_d);

    always_comb begin
        n_sum = (C+1)'(r_mx) + (C+1)'(r_mn);
        n_d   = r_mx - r_mn;
        // Above one half the divisor mirrors around the full scale.
        if (n_sum[C]) begin
            n_den = C'(LIG_DEN - n_sum);
        end else begin
            n_den = n_sum[C-1:0];
        end
        n_d6 = {w_d[C:0], 2'b00} + {w_d[C+1:0], 1'b0};
        case (r_br)
            rhsl_pkg::BR_RED: begin
                if (r_grn >= r_blu) begin
                    n_num = w_g - w_b;
                end else begin
                    n_num = n_d6 - (w_b - w_g);
                end
            end
            rhsl_pkg::BR_GREEN: n_num = {w_d[C+1:0], 1'b0} + w_b - w_r;
            rhsl_pkg::BR_BLUE:  n_num = {w_d[C:0], 2'b00} + w_r - w_g;
            default:            n_num = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sum  <= n_sum;
            r_d    <= n_d;
            r_den  <= n_den;
            r_d6   <= n_d6;
            r_num  <= n_num;
            r_grey <= (r_mx == r_mn);
        end
    end

    // Numerators: spread times (2^F - 1) by shift and subtract, hue numerator times 2^F.
    logic [C+F-1:0] w_sat_num;
    logic [C+F+2:0] w_hue_num;

    assign w_sat_num = {r_d, {F{1'b0}}} - (C+F)'(r_d);
    assign w_hue_num = {r_num, {F{1'b0}}};

    // Dividers: load stage plus one stage per quotient bit.
    logic [F-1:0] w_sat_quo, w_hue_quo;

    rhsl_div #(.DEN_W(C), .QUO_W(F)) u_sat_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (w_sat_num),
        .i_den (r_den),
        .o_quo (w_sat_quo)
    );

    rhsl_div #(.DEN_W(C + 3), .QUO_W(F)) u_hue_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (w_hue_num),
        .i_den (r_d6),
        .o_quo (w_hue_quo)
    );

    // The grey flag rides alongside the divider stages.
    logic [F:0] r_gry_d;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_gry_d <= {r_gry_d[F-1:0], r_grey};
        end
    end

    // The channel sum rides alongside the divider stages as well.
    logic [C:0] r_sum_d [0:F];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sum_d[0] <= r_sum;
            for (int k = 1; k <= F; k++) begin
                r_sum_d[k] <= r_sum_d[k-1];
            end
        end
    end

    // Lightness by reciprocal multiplication, taken just before the output.
    logic [LIG_PW-1:0] w_lig_prod;
    logic [F-1:0]      w_lig_quo;

    assign w_lig_prod = LIG_PW'(r_sum_d[F]) * LIG_PW'(LIG_MUL);
    assign w_lig_quo  = w_lig_prod[LIG_SHIFT +: F];

    // Output register: grey pixels force hue and saturation to zero.
    logic [F-1:0] r_hue, r_sat, r_lig;
    logic         r_out_grey;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hue      <= r_gry_d[F] ? '0 : w_hue_quo;
            r_sat      <= r_gry_d[F] ? '0 : w_sat_quo;
            r_lig      <= w_lig_quo;
            r_out_grey <= r_gry_d[F];
        end
    end

    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_lightness  = r_lig;

    // A held pipeline keeps every stage's valid bit.
    `RHSL_ASSERT(a_stall_holds_valids, !w_adv |=> $stable(r_vld), "valid bits moved during a stall")
    // An input transfer always lands in the first stage.
    `RHSL_ASSERT(a_accept_fills_stage1, i_valid && o_ready |=> r_vld[0], "transfer lost at entry")
    // A colored pixel always has a nonzero saturation.
    `RHSL_ASSERT(a_color_has_saturation, o_valid && !r_out_grey |-> o_saturation != '0,
        "colored pixel with zero saturation")

endmodule
